>>> design/cack_pkg.sv
// Shared constants, types and state codes of the cumulative ack receiver.
package cack_pkg;

  // Sequence space covered by the arrival bitmap
  localparam int SEQ_SPACE = 32768;

  // Fixed field widths
  localparam int SEQ_W   = 16;
  localparam int TOTAL_W = 16;
  localparam int ACK_W   = 15;

  // Width that holds a sequence number, the effective total and the pointer
  localparam int ET_W = ($clog2(SEQ_SPACE + 1) > SEQ_W) ? $clog2(SEQ_SPACE + 1) : SEQ_W;

  // Bitmap organization: rows of WORD_W bits
  localparam int WORD_W = 32;
  localparam int BIT_W  = $clog2(WORD_W);
  localparam int ROWS   = (SEQ_SPACE + WORD_W - 1) / WORD_W;
  localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;

  // Reset value of the total register
  localparam logic [TOTAL_W-1:0] TOTAL_RESET = TOTAL_W'(20000);

  // Sequencer states
  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_WALK
  } state_t;

  // Result of the first-zero search over one bitmap row
  typedef struct packed {
    logic             found;
    logic [BIT_W-1:0] idx;
  } scan_res_t;

endpackage

>>> design/cack_ram.sv
// Generic single-write, single-read RAM with registered read data.
module cack_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                                       clk,
  input  logic                                       wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                           wr_data,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                           rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

>>> design/cack_scan.sv
// First-zero search over one bitmap row, at or above a start bit.
module cack_scan
  import cack_pkg::*;
(
  input  logic [WORD_W-1:0] row_word,
  input  logic [BIT_W-1:0]  start_bit,
  output scan_res_t         res
);

  logic [WORD_W-1:0] holes;
  logic [WORD_W-1:0] lowest;
  logic [BIT_W-1:0]  idx;

  // Mask off bits below the start, then isolate the lowest hole
  assign holes  = ~row_word & ({WORD_W{1'b1}} << start_bit);
  assign lowest = holes & (~holes + WORD_W'(1));

  // Encode the one-hot hole position
  always_comb begin
    idx = '0;
    for (int i = 0; i < WORD_W; i++) begin
      if (lowest[i]) begin
        idx = idx | BIT_W'(i);
      end
    end
  end

  assign res.found = |holes;
  assign res.idx   = idx;

endmodule

>>> design/cumulative_ack_receiver_top.sv
// Top level of the cumulative ack receiver: sequencer, bitmap RAM and row scanner.
//
//  channel   ports                                   handshake
//  -------   -------------------------------------   ----------------------------
//  input     in_seq_number                           taken when start && !busy
//  result    out_ack_number, out_all_received,       out_valid strobe, one cycle
//            out_seq_out_of_range
//  config    cfg_wr_data                             written when cfg_wr_en
//
// An out-of-range number is answered straight from idle; any other number takes a row
// read, then a read-modify-write. When it fills the gap at the expected pointer, the walk
// goes on into each further 32-bit row, since the single RAM read port and the
// shared row scanner look at one row per cycle. The result strobes in the cycle
// after the item's last cycle. After reset the bitmap is cleared one row per cycle,
// all ROWS (1024) rows with busy high. The receiver cannot stall the result.
module cumulative_ack_receiver_top
  import cack_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [SEQ_W-1:0]   in_seq_number,
  output logic               out_valid,
  output logic [ACK_W-1:0]   out_ack_number,
  output logic               out_all_received,
  output logic               out_seq_out_of_range,
  input  logic               cfg_wr_en,
  input  logic [TOTAL_W-1:0] cfg_wr_data
);

  state_t             state_r, state_nxt;
  logic [ROW_W-1:0]   clr_row_r, clr_row_nxt;
  logic [ET_W-1:0]    seq_r, seq_nxt;
  logic [ROW_W-1:0]   walk_row_r, walk_row_nxt;
  logic [ET_W-1:0]    next_exp_r, next_exp_nxt;
  logic [ACK_W-1:0]   last_ack_r, last_ack_nxt;
  logic [TOTAL_W-1:0] total_r;
  logic               out_valid_r, out_valid_nxt;
  logic [ACK_W-1:0]   out_ack_r, out_ack_nxt;
  logic               out_all_r, out_all_nxt;
  logic               out_oor_r, out_oor_nxt;

  logic               ram_we;
  logic [ROW_W-1:0]   ram_waddr;
  logic [WORD_W-1:0]  ram_wdata;
  logic [ROW_W-1:0]   ram_raddr;
  logic [WORD_W-1:0]  ram_rdata;

  logic [ET_W-1:0]    total_ext;
  logic [ET_W-1:0]    total_eff;
  logic [ET_W-1:0]    in_seq_ext;
  logic [ROW_W-1:0]   seq_row;
  logic [BIT_W-1:0]   seq_bit;
  logic               seq_match;
  logic [WORD_W-1:0]  scan_word;
  logic [BIT_W-1:0]   scan_pos;
  logic [ROW_W-1:0]   scan_row;
  scan_res_t          scan_res;
  logic [ET_W-1:0]    row_ext;
  logic [ET_W-1:0]    cand;
  logic               past_total;
  logic               walk_stop;
  logic [ET_W-1:0]    ne_new;
  logic [ACK_W-1:0]   ack_new;

  // Saturate the total to the sequence space
  assign total_ext  = ET_W'(total_r);
  assign total_eff  = (total_ext > ET_W'(SEQ_SPACE)) ? ET_W'(SEQ_SPACE) : total_ext;
  assign in_seq_ext = ET_W'(in_seq_number);

  assign seq_row   = seq_r[BIT_W +: ROW_W];
  assign seq_bit   = seq_r[BIT_W-1:0];
  assign seq_match = (seq_r == next_exp_r);

  // Feed the shared scanner: merged row on the first read, raw rows while walking
  always_comb begin
    if (state_r == ST_READ) begin
      scan_word = ram_rdata | (WORD_W'(1) << seq_bit);
      scan_pos  = seq_bit;
      scan_row  = seq_row;
    end else begin
      scan_word = ram_rdata;
      scan_pos  = '0;
      scan_row  = walk_row_r;
    end
  end

  cack_scan u_scan (
    .row_word  (scan_word),
    .start_bit (scan_pos),
    .res       (scan_res)
  );

  // Candidate pointer: the hole found, or the start of the next row; clamp at total
  assign row_ext    = ET_W'(scan_row);
  assign cand       = scan_res.found ? ((row_ext << BIT_W) | ET_W'(scan_res.idx))
                                     : ((row_ext + ET_W'(1)) << BIT_W);
  assign past_total = (cand >= total_eff);
  assign walk_stop  = scan_res.found || past_total;
  assign ne_new     = past_total ? total_eff : cand;
  assign ack_new    = ACK_W'(ne_new - ET_W'(1));

  cack_ram #(
    .WIDTH (WORD_W),
    .DEPTH (ROWS)
  ) u_map (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  // Sequencer: clear, accept, read-modify-write, walk
  always_comb begin
    state_nxt     = state_r;
    clr_row_nxt   = clr_row_r;
    seq_nxt       = seq_r;
    walk_row_nxt  = walk_row_r;
    next_exp_nxt  = next_exp_r;
    last_ack_nxt  = last_ack_r;
    out_valid_nxt = 1'b0;
    out_ack_nxt   = out_ack_r;
    out_all_nxt   = out_all_r;
    out_oor_nxt   = out_oor_r;
    ram_we        = 1'b0;
    ram_waddr     = seq_row;
    ram_wdata     = scan_word;
    ram_raddr     = in_seq_ext[BIT_W +: ROW_W];

    unique case (state_r)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_row_r;
        ram_wdata = '0;
        if (clr_row_r == ROW_W'(ROWS - 1)) begin
          state_nxt = ST_IDLE;
        end else begin
          clr_row_nxt = clr_row_r + ROW_W'(1);
        end
      end

      ST_IDLE: begin
        if (start) begin
          seq_nxt = in_seq_ext;
          if (in_seq_ext >= total_eff) begin
            // Drop the number, answer at once
            out_valid_nxt = 1'b1;
            out_ack_nxt   = last_ack_r;
            out_all_nxt   = (next_exp_r >= total_eff);
            out_oor_nxt   = 1'b1;
          end else begin
            state_nxt = ST_READ;
          end
        end
      end

      ST_READ: begin
        ram_we = 1'b1;
        if (!seq_match) begin
          // Out of order or duplicate: mark only, hold the ack
          state_nxt     = ST_IDLE;
          out_valid_nxt = 1'b1;
          out_ack_nxt   = last_ack_r;
          out_all_nxt   = (next_exp_r >= total_eff);
          out_oor_nxt   = 1'b0;
        end else if (walk_stop) begin
          state_nxt     = ST_IDLE;
          next_exp_nxt  = ne_new;
          last_ack_nxt  = ack_new;
          out_valid_nxt = 1'b1;
          out_ack_nxt   = ack_new;
          out_all_nxt   = (ne_new >= total_eff);
          out_oor_nxt   = 1'b0;
        end else begin
          // Row full from the pointer up: advance to the next row
          state_nxt    = ST_WALK;
          walk_row_nxt = seq_row + ROW_W'(1);
          ram_raddr    = seq_row + ROW_W'(1);
        end
      end

      ST_WALK: begin
        if (walk_stop) begin
          state_nxt     = ST_IDLE;
          next_exp_nxt  = ne_new;
          last_ack_nxt  = ack_new;
          out_valid_nxt = 1'b1;
          out_ack_nxt   = ack_new;
          out_all_nxt   = (ne_new >= total_eff);
          out_oor_nxt   = 1'b0;
        end else begin
          walk_row_nxt = walk_row_r + ROW_W'(1);
          ram_raddr    = walk_row_r + ROW_W'(1);
        end
      end

      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_row_r   <= '0;
      next_exp_r  <= '0;
      last_ack_r  <= '0;
      total_r     <= TOTAL_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_row_r   <= clr_row_nxt;
      next_exp_r  <= next_exp_nxt;
      last_ack_r  <= last_ack_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        total_r <= cfg_wr_data;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    seq_r      <= seq_nxt;
    walk_row_r <= walk_row_nxt;
    out_ack_r  <= out_ack_nxt;
    out_all_r  <= out_all_nxt;
    out_oor_r  <= out_oor_nxt;
  end

  assign busy                 = (state_r != ST_IDLE);
  assign out_valid            = out_valid_r;
  assign out_ack_number       = out_ack_r;
  assign out_all_received     = out_all_r;
  assign out_seq_out_of_range = out_oor_r;

`ifndef SYNTHESIS
  // An accepted word either answers next cycle or keeps the block busy
  a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (out_valid || busy))
    else $error("accepted word neither answered nor in progress");

  // The row read always ends in a result or a walk
  a_read_exit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_READ) |=> (out_valid_r || state_r == ST_WALK))
    else $error("row read did not finish or walk");

  // The expected pointer never passes the sequence space
  a_ptr_bound: assert property (@(posedge clk) disable iff (!rst_n)
    next_exp_r <= ET_W'(SEQ_SPACE))
    else $error("expected pointer beyond sequence space");
`endif

endmodule

>>> tb/sv/cumulative_ack_receiver_top_test.sv
// Self-checking testbench of the cumulative ack receiver: directed table, then random phases.
`timescale 1ns / 1ps

module cumulative_ack_receiver_top_test;
  import cack_pkg::*;

  // One result word as the block reports it
  typedef struct packed {
    logic [ACK_W-1:0] ack_number;
    logic             all_received;
    logic             seq_out_of_range;
  } ack_word_t;

  typedef enum logic {
    ROW_ITEM,
    ROW_CFG
  } row_kind_t;

  // Directed row: a sequence number or a new total, with an optional typed-in answer
  typedef struct packed {
    row_kind_t        kind;
    logic [SEQ_W-1:0] value;
    logic             typed;
    ack_word_t        want;
  } dir_row_t;

  localparam int N_DIR = 25;

  dir_row_t dir_rows [N_DIR] = '{
    '{ROW_ITEM, 16'd1,     1'b1, '{15'd0, 1'b0, 1'b0}},  // out of order from reset
    '{ROW_ITEM, 16'd0,     1'b1, '{15'd1, 1'b0, 1'b0}},  // fill the gap, walk past 1
    '{ROW_ITEM, 16'd65535, 1'b1, '{15'd1, 1'b0, 1'b1}},
    '{ROW_ITEM, 16'd20000, 1'b1, '{15'd1, 1'b0, 1'b1}},  // exactly at the total
    '{ROW_ITEM, 16'd19999, 1'b1, '{15'd1, 1'b0, 1'b0}},
    '{ROW_ITEM, 16'd1,     1'b1, '{15'd1, 1'b0, 1'b0}},  // duplicate
    '{ROW_ITEM, 16'd2,     1'b1, '{15'd2, 1'b0, 1'b0}},
    '{ROW_CFG,  16'd0,     1'b0, '0},                    // total of zero
    '{ROW_ITEM, 16'd0,     1'b1, '{15'd2, 1'b1, 1'b1}},
    '{ROW_ITEM, 16'd3,     1'b1, '{15'd2, 1'b1, 1'b1}},
    '{ROW_CFG,  16'd3,     1'b0, '0},                    // total equal to the pointer
    '{ROW_ITEM, 16'd2,     1'b1, '{15'd2, 1'b1, 1'b0}},  // arrival after completion
    '{ROW_ITEM, 16'd3,     1'b1, '{15'd2, 1'b1, 1'b1}},
    '{ROW_CFG,  16'd65535, 1'b0, '0},                    // saturates to the sequence space
    '{ROW_ITEM, 16'd32768, 1'b1, '{15'd2, 1'b0, 1'b1}},
    '{ROW_ITEM, 16'd32767, 1'b1, '{15'd2, 1'b0, 1'b0}},
    '{ROW_ITEM, 16'd4,     1'b0, '0},
    '{ROW_ITEM, 16'd3,     1'b0, '0},                    // walk over 3 and 4
    '{ROW_CFG,  16'd32768, 1'b0, '0},
    '{ROW_ITEM, 16'd32767, 1'b1, '{15'd4, 1'b0, 1'b0}},
    '{ROW_ITEM, 16'd65535, 1'b1, '{15'd4, 1'b0, 1'b1}},
    '{ROW_CFG,  16'd1,     1'b0, '0},                    // total below the pointer
    '{ROW_ITEM, 16'd0,     1'b1, '{15'd4, 1'b1, 1'b0}},
    '{ROW_ITEM, 16'd1,     1'b1, '{15'd4, 1'b1, 1'b1}},
    '{ROW_CFG,  16'd20000, 1'b0, '0}
  };

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic [SEQ_W-1:0]   in_seq_number;
  logic               out_valid;
  logic [ACK_W-1:0]   out_ack_number;
  logic               out_all_received;
  logic               out_seq_out_of_range;
  logic               cfg_wr_en;
  logic [TOTAL_W-1:0] cfg_wr_data;

  // Predictor state
  bit                 arrived [SEQ_SPACE];
  int unsigned        next_exp = 0;
  logic [ACK_W-1:0]   last_ack = '0;
  logic [TOTAL_W-1:0] total_msgs = TOTAL_RESET;

  ack_word_t acks_due [$];
  int        n_fail  = 0;
  int        n_used  = 0;
  bit        no_gaps = 1'b0;

  cumulative_ack_receiver_top i_dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .start                (start),
    .busy                 (busy),
    .in_seq_number        (in_seq_number),
    .out_valid            (out_valid),
    .out_ack_number       (out_ack_number),
    .out_all_received     (out_all_received),
    .out_seq_out_of_range (out_seq_out_of_range),
    .cfg_wr_en            (cfg_wr_en),
    .cfg_wr_data          (cfg_wr_data)
  );

  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Record one arrival and return the ack word it yields
  function automatic ack_word_t track_arrival(input logic [SEQ_W-1:0] seq);
    int unsigned lim;
    ack_word_t   r;
    lim = (total_msgs > SEQ_SPACE) ? SEQ_SPACE : total_msgs;
    r.seq_out_of_range = (seq >= lim);
    if (!r.seq_out_of_range) begin
      arrived[seq] = 1'b1;
      // advance the pointer past every contiguous arrival
      if (seq == next_exp) begin
        while (next_exp < lim && arrived[next_exp]) next_exp++;
        last_ack = ACK_W'(next_exp - 1);
      end
    end
    r.ack_number   = last_ack;
    r.all_received = (next_exp >= lim);
    return r;
  endfunction

  // Hand one sequence number to the block after a random gap
  task automatic send_seq(input logic [SEQ_W-1:0] seq, input bit typed = 1'b0,
                          input ack_word_t want = '0);
    int        gap;
    ack_word_t got;
    gap = no_gaps ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start         <= 1'b1;
    in_seq_number <= seq;
    do @(posedge clk); while (busy);
    got = track_arrival(seq);
    if (!got.seq_out_of_range) n_used++;
    acks_due.push_back(typed ? want : got);
  endtask

  // Write the total once every pending word has come back
  task automatic write_total(input logic [TOTAL_W-1:0] value);
    start <= 1'b0;
    while (acks_due.size() != 0 || busy) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en  <= 1'b0;
    total_msgs  = value;
  endtask

  // Compare each strobed word with the oldest expectation
  always @(posedge clk) begin
    ack_word_t exp_w;
    if (rst_n && out_valid) begin
      if (acks_due.size() == 0) begin
        $error("ack word with none expected: ack_number %0d", out_ack_number);
        n_fail++;
      end else begin
        exp_w = acks_due.pop_front();
        if (out_ack_number !== exp_w.ack_number) begin
          $error("ack_number: expected %0d, got %0d", exp_w.ack_number, out_ack_number);
          n_fail++;
        end
        if (out_all_received !== exp_w.all_received) begin
          $error("all_received: expected %0d, got %0d", exp_w.all_received, out_all_received);
          n_fail++;
        end
        if (out_seq_out_of_range !== exp_w.seq_out_of_range) begin
          $error("seq_out_of_range: expected %0d, got %0d", exp_w.seq_out_of_range,
                 out_seq_out_of_range);
          n_fail++;
        end
      end
    end
  end

  initial begin
    logic [TOTAL_W-1:0] new_total;
    int                 quota;
    int                 sent;
    int                 pick;
    int                 len;
    int unsigned        base;

    rst_n         = 1'b0;
    start         = 1'b0;
    in_seq_number = '0;
    cfg_wr_en     = 1'b0;
    cfg_wr_data   = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Walk the directed table
    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        write_total(dir_rows[i].value);
      end else begin
        send_seq(dir_rows[i].value, dir_rows[i].typed, dir_rows[i].want);
      end
    end

    // Random phases, each under its own total
    for (int ph = 0; ph < 8; ph++) begin
      case (ph) inside
        0: new_total = 16'hFFFF;
        1, 3, 6: new_total = TOTAL_W'(next_exp + $urandom_range(30, 200));
        2: new_total = '0;
        4: new_total = 16'h8000;
        5: new_total = TOTAL_W'($urandom_range(1, next_exp));
        default: new_total = 16'h7FFF;
      endcase
      write_total(new_total);
      quota  = (ph == 2) ? 10 : ((ph == 5) ? 40 : 200);
      n_used = 0;
      sent   = 0;
      while (n_used < quota && sent < quota + quota / 4) begin
        // switch between gapped and back-to-back stretches
        if ($urandom_range(0, 15) == 0) no_gaps = ~no_gaps;
        pick = $urandom_range(0, 99);
        base = next_exp;
        if (pick < 45) begin
          // arrival inside a window above the pointer
          send_seq(SEQ_W'(base + $urandom_range(0, 40)));
          sent++;
        end else if (pick < 60) begin
          // run of later numbers, then the missing one to force a long walk
          len = $urandom_range(2, 80);
          for (int k = len; k >= 1; k--) send_seq(SEQ_W'(base + k));
          send_seq(SEQ_W'(base));
          sent += len + 1;
        end else if (pick < 70) begin
          send_seq(SEQ_W'($urandom_range(0, (base > 0) ? base - 1 : 0)));
          sent++;
        end else if (pick < 82) begin
          send_seq(SEQ_W'($urandom));
          sent++;
        end else if (pick < 92) begin
          // hug the total from both sides
          send_seq(SEQ_W'(int'(total_msgs) - 2 + $urandom_range(0, 3)));
          sent++;
        end else begin
          send_seq(SEQ_W'($urandom_range(0, SEQ_SPACE - 1)));
          sent++;
        end
      end
    end

    // Drain, then watch for stray words
    start <= 1'b0;
    while (acks_due.size() != 0) @(posedge clk);
    repeat (64) @(posedge clk);
    if (n_fail == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Hard stop if the block hangs
  initial begin
    #2000000;
    $display("Verification failed");
    $finish;
  end

endmodule
